FILE: hdl/imh_pkg.sv
package imh_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_REKEY  = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  item_handle;
        logic [39:0] item_key;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  min_handle;
        logic [39:0] min_key;
        logic [9:0]  popped_handle;
        logic [10:0] entry_count;
        logic        heap_empty;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEC,
        S_POPH,
        S_CHK1,
        S_CHK2,
        S_R0,
        S_R1,
        S_R2,
        S_U0,
        S_U1,
        S_U2,
        S_D0,
        S_D1,
        S_D2,
        S_D3,
        S_FIN,
        S_TOP,
        S_TOP1,
        S_TOP2
    } t_state;

endpackage

FILE: hdl/imh_ram.sv
module imh_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/indexed_min_heap_top.sv
// After the accepting edge the operation is decoded and the handle is checked (pop
// reads the root handle instead); remove and pop then fetch the last entry. Sift up
// reads the parent at each level, sift down both children until it stops, then the
// entry is written back and the top is read. One operation at a time, limited by the
// single read port of the slot memory and the handle memory walked per level.
// Reset: synchronous active low; clears count and control, memories are not cleared.
module indexed_min_heap_top #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  imh_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output imh_pkg::t_out o_out_data
);
    import imh_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int HD = (CAPACITY < 1024) ? CAPACITY : 1024;
    localparam int HW = (HD > 1) ? $clog2(HD) : 1;
    localparam int KB = KEY_BITS;
    localparam int IW = SW + KB;

    t_state r_state, n_state;

    logic [1:0]    r_op;
    logic [9:0]    r_h;
    logic [KB-1:0] r_key;
    logic [SW-1:0] r_count, n_count;
    logic [SW-1:0] r_p, n_p;
    logic [HW-1:0] r_hc, n_hc;
    logic [KB-1:0] r_kc, n_kc;
    logic [HW-1:0] r_hl, n_hl;
    logic [KB-1:0] r_kl, n_kl;
    logic [HW-1:0] r_hr, n_hr;
    logic          r_down, n_down;
    logic          r_moved, n_moved;
    logic [1:0]    r_status, n_status;
    logic [9:0]    r_popped, n_popped;
    t_out          r_out, n_out;
    logic          r_ov, n_ov;

    logic          heap_we;
    logic [SW-1:0] heap_waddr, heap_raddr;
    logic [HW-1:0] heap_wdata, heap_rd;
    logic          item_we;
    logic [HW-1:0] item_waddr, item_raddr;
    logic [IW-1:0] item_wdata, item_rd;

    logic [KB-1:0] rd_key;
    logic [SW-1:0] rd_pos;
    logic [SW:0]   c_left, c_right, cnt_x;
    logic          has_left, has_right, right_sel, present, out_free, accept;
    logic [HW-1:0] ch_h;
    logic [KB-1:0] ch_k;
    logic [SW-1:0] ch_p;

    imh_ram #(.DEPTH(CAPACITY + 1), .WIDTH(HW)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (heap_we),
        .i_waddr(heap_waddr),
        .i_wdata(heap_wdata),
        .i_raddr(heap_raddr),
        .o_rdata(heap_rd)
    );

    imh_ram #(.DEPTH(HD), .WIDTH(IW)) u_item_ram (
        .i_clk  (i_clk),
        .i_we   (item_we),
        .i_waddr(item_waddr),
        .i_wdata(item_wdata),
        .i_raddr(item_raddr),
        .o_rdata(item_rd)
    );

    assign rd_key    = item_rd[KB-1:0];
    assign rd_pos    = item_rd[IW-1:KB];
    assign cnt_x     = {1'b0, r_count};
    assign c_left    = {r_p, 1'b0};
    assign c_right   = c_left + (SW+1)'(1);
    assign has_left  = c_left <= cnt_x;
    assign has_right = c_right <= cnt_x;
    assign right_sel = has_right && (rd_key < r_kl);
    assign ch_h      = right_sel ? r_hr : r_hl;
    assign ch_k      = right_sel ? rd_key : r_kl;
    assign ch_p      = right_sel ? c_right[SW-1:0] : c_left[SW-1:0];
    assign present   = (r_p != '0) && (r_p <= r_count) && (heap_rd == r_h[HW-1:0]);
    assign out_free  = !r_ov || !i_out_stall;
    assign accept    = (r_state == S_IDLE) && i_in_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (r_op == OP_POP) begin
                    n_state = (r_count == '0) ? S_TOP : S_POPH;
                end else if (32'(r_h) >= CAPACITY) begin
                    n_state = S_TOP;
                end else begin
                    n_state = S_CHK1;
                end
            end
            S_POPH: n_state = S_R0;
            S_CHK1: n_state = S_CHK2;
            S_CHK2: begin
                if (present) begin
                    if (r_op == OP_INSERT) n_state = S_TOP;
                    else if (r_op == OP_REMOVE) n_state = S_R0;
                    else n_state = S_U0;
                end else if (r_op == OP_INSERT && r_count != SW'(CAPACITY)) begin
                    n_state = S_U0;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_R0: n_state = S_R1;
            S_R1: n_state = S_R2;
            S_R2: n_state = (r_p == r_count) ? S_TOP : S_U0;
            S_U0: begin
                if (r_p == SW'(1)) n_state = (r_down && !r_moved) ? S_D0 : S_FIN;
                else n_state = S_U1;
            end
            S_U1: n_state = S_U2;
            S_U2: begin
                if (r_kc < rd_key) n_state = S_U0;
                else n_state = (r_down && !r_moved) ? S_D0 : S_FIN;
            end
            S_D0: n_state = has_left ? S_D1 : S_FIN;
            S_D1: n_state = S_D2;
            S_D2: n_state = S_D3;
            S_D3: n_state = (r_kc <= ch_k) ? S_FIN : S_D0;
            S_FIN: n_state = S_TOP;
            S_TOP: n_state = S_TOP1;
            S_TOP1: n_state = S_TOP2;
            S_TOP2: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_p        = r_p;
        n_hc       = r_hc;
        n_kc       = r_kc;
        n_hl       = r_hl;
        n_kl       = r_kl;
        n_hr       = r_hr;
        n_down     = r_down;
        n_moved    = r_moved;
        n_status   = r_status;
        n_popped   = r_popped;
        n_out      = r_out;
        n_ov       = r_ov && i_out_stall;
        heap_we    = 1'b0;
        heap_waddr = '0;
        heap_wdata = '0;
        heap_raddr = '0;
        item_we    = 1'b0;
        item_waddr = '0;
        item_wdata = '0;
        item_raddr = '0;
        case (r_state)
            S_IDLE: begin
                n_status = ST_OK;
                n_popped = '0;
            end
            S_DEC: begin
                if (r_op == OP_POP) begin
                    if (r_count == '0) n_status = ST_ABSENT;
                    heap_raddr = SW'(1);
                end else if (32'(r_h) >= CAPACITY) begin
                    n_status = ST_ABSENT;
                end else begin
                    item_raddr = r_h[HW-1:0];
                end
            end
            S_POPH: begin
                n_popped = 10'(heap_rd);
                n_p      = SW'(1);
            end
            S_CHK1: begin
                n_p        = rd_pos;
                heap_raddr = rd_pos;
            end
            S_CHK2: begin
                n_hc    = r_h[HW-1:0];
                n_kc    = r_key;
                n_moved = 1'b0;
                n_down  = (r_op != OP_INSERT);
                if (present) begin
                    if (r_op == OP_INSERT) n_status = ST_PRESENT;
                end else if (r_op == OP_INSERT) begin
                    if (r_count == SW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + SW'(1);
                        n_p     = r_count + SW'(1);
                    end
                end else begin
                    n_status = ST_ABSENT;
                end
            end
            S_R0: heap_raddr = r_count;
            S_R1: begin
                n_hl       = heap_rd;
                item_raddr = heap_rd;
            end
            S_R2: begin
                n_count = r_count - SW'(1);
                n_hc    = r_hl;
                n_kc    = rd_key;
                n_down  = 1'b1;
                n_moved = 1'b0;
            end
            S_U0: heap_raddr = r_p >> 1;
            S_U1: begin
                n_hl       = heap_rd;
                item_raddr = heap_rd;
            end
            S_U2: begin
                if (r_kc < rd_key) begin
                    heap_we    = 1'b1;
                    heap_waddr = r_p;
                    heap_wdata = r_hl;
                    item_we    = 1'b1;
                    item_waddr = r_hl;
                    item_wdata = {r_p, rd_key};
                    n_p        = r_p >> 1;
                    n_moved    = 1'b1;
                end
            end
            S_D0: heap_raddr = c_left[SW-1:0];
            S_D1: begin
                n_hl       = heap_rd;
                item_raddr = heap_rd;
                heap_raddr = c_right[SW-1:0];
            end
            S_D2: begin
                n_kl       = rd_key;
                n_hr       = heap_rd;
                item_raddr = heap_rd;
            end
            S_D3: begin
                if (r_kc > ch_k) begin
                    heap_we    = 1'b1;
                    heap_waddr = r_p;
                    heap_wdata = ch_h;
                    item_we    = 1'b1;
                    item_waddr = ch_h;
                    item_wdata = {r_p, ch_k};
                    n_p        = ch_p;
                end
            end
            S_FIN: begin
                heap_we    = 1'b1;
                heap_waddr = r_p;
                heap_wdata = r_hc;
                item_we    = 1'b1;
                item_waddr = r_hc;
                item_wdata = {r_p, r_kc};
            end
            S_TOP: heap_raddr = SW'(1);
            S_TOP1: begin
                n_hl       = heap_rd;
                item_raddr = heap_rd;
            end
            S_TOP2: begin
                item_raddr = r_hl;
                if (out_free) begin
                    n_ov                = 1'b1;
                    n_out.status        = r_status;
                    n_out.min_handle    = (r_count == '0) ? '0 : 10'(r_hl);
                    n_out.min_key       = (r_count == '0) ? '0 : 40'(rd_key);
                    n_out.popped_handle = r_popped;
                    n_out.entry_count   = 11'(r_count);
                    n_out.heap_empty    = (r_count == '0);
                end
            end
            default: begin
                n_ov = r_ov && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_data.operation;
            r_h   <= i_in_data.item_handle;
            r_key <= KB'(i_in_data.item_key);
        end
        r_p      <= n_p;
        r_hc     <= n_hc;
        r_kc     <= n_kc;
        r_hl     <= n_hl;
        r_kl     <= n_kl;
        r_hr     <= n_hr;
        r_down   <= n_down;
        r_moved  <= n_moved;
        r_status <= n_status;
        r_popped <= n_popped;
        r_out    <= n_out;
    end

endmodule

FILE: test/indexed_min_heap_checker.sv
module indexed_min_heap_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  imh_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  imh_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_ops_seen
);
    import imh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 1024;

    logic [9:0]  slot_handle [1:CAP];
    logic [10:0] handle_slot [0:CAP-1];
    logic [39:0] handle_key  [0:CAP-1];
    logic        handle_held [0:CAP-1];
    int          held;
    t_out        expected_q [$];

    function automatic logic [39:0] key_at(int p);
        return handle_key[slot_handle[p]];
    endfunction

    function automatic void swap_slots(int i, int j);
        logic [9:0] hi, hj;
        hi = slot_handle[i];
        hj = slot_handle[j];
        slot_handle[i] = hj;
        slot_handle[j] = hi;
        handle_slot[hj] = 11'(i);
        handle_slot[hi] = 11'(j);
    endfunction

    function automatic void sift_up(int p);
        while (p > 1 && key_at(p) < key_at(p / 2)) begin
            swap_slots(p, p / 2);
            p = p / 2;
        end
    endfunction

    function automatic void sift_down(int p);
        int c;
        c = 2 * p;
        while (c <= held) begin
            if (c < held && key_at(c + 1) < key_at(c)) c++;
            if (key_at(p) <= key_at(c)) break;
            swap_slots(p, c);
            p = c;
            c = 2 * p;
        end
    endfunction

    function automatic void drop_slot(int p);
        logic [9:0] h;
        h = slot_handle[p];
        swap_slots(p, held);
        held--;
        handle_held[h] = 1'b0;
        if (p <= held) begin
            sift_up(p);
            sift_down(p);
        end
    endfunction

    function automatic t_out heap_step(t_in it);
        t_out r;
        int h;
        r = '0;
        r.status = ST_OK;
        h = it.item_handle;
        if (it.operation == OP_POP) begin
            if (held == 0) r.status = ST_ABSENT;
            else begin
                r.popped_handle = slot_handle[1];
                drop_slot(1);
            end
        end else if (it.operation == OP_INSERT) begin
            if (handle_held[h]) r.status = ST_PRESENT;
            else if (held >= CAP) r.status = ST_FULL;
            else begin
                held++;
                slot_handle[held] = 10'(h);
                handle_slot[h] = 11'(held);
                handle_key[h] = it.item_key;
                handle_held[h] = 1'b1;
                sift_up(held);
            end
        end else if (!handle_held[h]) begin
            r.status = ST_ABSENT;
        end else if (it.operation == OP_REMOVE) begin
            drop_slot(handle_slot[h]);
        end else begin
            handle_key[h] = it.item_key;
            sift_up(handle_slot[h]);
            sift_down(handle_slot[h]);
        end
        if (held != 0) begin
            r.min_handle = slot_handle[1];
            r.min_key = key_at(1);
        end
        r.entry_count = 11'(held);
        r.heap_empty = (held == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_ops_seen = 0;
        o_pending = 0;
        held = 0;
        for (int i = 0; i < CAP; i++) handle_held[i] = 1'b0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            expected_q.push_back(heap_step(i_in_data));
            o_ops_seen++;
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(i_out_data), 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (i_out_data.status != want.status)
                    report_mismatch("status", 64'(i_out_data.status), 64'(want.status));
                if (i_out_data.min_handle != want.min_handle)
                    report_mismatch("min_handle", 64'(i_out_data.min_handle),
                                    64'(want.min_handle));
                if (i_out_data.min_key != want.min_key)
                    report_mismatch("min_key", 64'(i_out_data.min_key), 64'(want.min_key));
                if (i_out_data.popped_handle != want.popped_handle)
                    report_mismatch("popped_handle", 64'(i_out_data.popped_handle),
                                    64'(want.popped_handle));
                if (i_out_data.entry_count != want.entry_count)
                    report_mismatch("entry_count", 64'(i_out_data.entry_count),
                                    64'(want.entry_count));
                if (i_out_data.heap_empty != want.heap_empty)
                    report_mismatch("heap_empty", 64'(i_out_data.heap_empty),
                                    64'(want.heap_empty));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: test/indexed_min_heap_top_tb.sv
module indexed_min_heap_top_tb;
    import imh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;
    int   fail_count;
    int   pending;
    int   ops_seen;
    int   cycle_count;
    bit   calm;
    int   fill_target;

    indexed_min_heap_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    indexed_min_heap_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ops_seen   (ops_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver stall bursts
    initial begin
        out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // most handles used by random traffic come from a small pool so hits are common
    logic [9:0] pool [0:47];

    task automatic send(logic [1:0] op, logic [9:0] h, logic [39:0] k);
        in_valid <= 1'b1;
        in_data <= '{operation: op, item_handle: h, item_key: k};
        do @(posedge i_clk); while (in_stall);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    function automatic logic [39:0] rand_key();
        case ($urandom_range(0, 3))
            0: return 40'({$urandom, $urandom});
            1: return 40'($urandom_range(0, 15));
            2: return 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 3));
            default: return 40'($urandom_range(0, 1000));
        endcase
    endfunction

    initial begin
        logic [1:0] op;
        calm = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        for (int i = 0; i < 48; i++) pool[i] = 10'($urandom_range(0, 1023));
        pool[0] = 10'd0;
        pool[1] = 10'h3FF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_POP, 10'd0, 40'd0);
        send(OP_REMOVE, 10'd5, 40'd0);
        send(OP_REKEY, 10'h3FF, 40'd1);
        send(OP_INSERT, 10'd0, 40'hFF_FFFF_FFFF);
        send(OP_INSERT, 10'd0, 40'd3);
        send(OP_INSERT, 10'h3FF, 40'd0);
        send(OP_INSERT, 10'h155, 40'h55_5555_5555);
        send(OP_INSERT, 10'h2AA, 40'hAA_AAAA_AAAA);
        send(OP_INSERT, 10'd7, 40'd0);
        send(OP_REKEY, 10'h3FF, 40'hFF_FFFF_FFFF);
        send(OP_REKEY, 10'h2AA, 40'd0);
        send(OP_REMOVE, 10'd7, 40'd0);
        send(OP_REMOVE, 10'd7, 40'd0);
        send(OP_POP, 10'd0, 40'd0);
        send(OP_POP, 10'd0, 40'd0);
        send(OP_POP, 10'd0, 40'd0);
        send(OP_POP, 10'd0, 40'd0);
        send(OP_POP, 10'd0, 40'd0);

        for (int n = 0; n < 580; n++) begin
            if (n == 500) calm = 1'b1;
            fill_target = $urandom_range(0, 9);
            op = (fill_target < 4) ? OP_INSERT : 2'($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0)
                send(op, 10'($urandom_range(0, 1023)), rand_key());
            else
                send(op, pool[$urandom_range(0, 47)], rand_key());
        end
        in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Ran %0d heap operations: inserts, removes, rekeys and pops,", ops_seen);
        $display("including empty-heap, duplicate and absent-handle cases under random stalls.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
